// File: sv/caf_pkg.sv
// Shared constants, types and the fixed byte table of the anchor finder.
// Depends on nothing; the hash stage, the anchor stage and the top import it.
package caf_pkg;

  localparam int WINDOW = 32;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int HASH_W = 64;
  localparam int POS_W  = 32;

  // Rotation of the outgoing word, and its complement for the wrap-around part.
  localparam int ROT_OUT  = WINDOW % HASH_W;
  localparam int ROT_BACK = (HASH_W - ROT_OUT) % HASH_W;

  localparam logic [HASH_W-1:0] TABLE_SEED = 64'h46a7c15d3b92e801;
  localparam logic [HASH_W-1:0] MIX_STEP   = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_W-1:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MIX_MUL2   = 64'h94d049bb133111eb;
  localparam logic [HASH_W-1:0] MASK_RESET = 64'd63;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [POS_W-1:0]  POS_MAX   = '1;

  typedef logic [HASH_W-1:0] table_t [256];

  // Candidate handed from the hash stage to the anchor check.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
    logic              full;
  } cand_t;

  // Entry k is the (k+1)-th SplitMix64 output; evaluated at elaboration only.
  function automatic table_t build_table();
    table_t            t;
    logic [HASH_W-1:0] seq;
    logic [HASH_W-1:0] z;
    seq = TABLE_SEED;
    for (int k = 0; k < 256; k++) begin
      seq  = seq + MIX_STEP;
      z    = seq;
      z    = (z ^ (z >> 30)) * MIX_MUL1;
      z    = (z ^ (z >> 27)) * MIX_MUL2;
      t[k] = z ^ (z >> 31);
    end
    return t;
  endfunction

  localparam table_t BYTE_TABLE = build_table();

endpackage

// File: sv/caf_in_if.sv
// Byte channel of the anchor finder: valid/ready plus one stream byte.
// Depends on nothing.
interface caf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       stream_start;

  modport source (output valid, output byte_value, output stream_start, input ready);
  modport sink   (input valid, input byte_value, input stream_start, output ready);
endinterface

// File: sv/caf_out_if.sv
// Anchor channel of the anchor finder: valid/ready plus the window start offset.
// Depends on nothing.
interface caf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] anchor_position;

  modport source (output valid, output anchor_position, input ready);
  modport sink   (input valid, input anchor_position, output ready);
endinterface

// File: sv/caf_hash_stage.sv
// Rolling buzhash state: window shift line, hash, fill count and position.
// Loads one candidate per accepted byte. Depends on caf_pkg.
module caf_hash_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     byte_value,
  input  logic           stream_start,
  output logic           cand_valid,
  output caf_pkg::cand_t cand,
  input  logic           cand_take
);
  import caf_pkg::*;

  logic [7:0]        window [WINDOW];
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] hash_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;

  logic [HASH_W-1:0] hash_cur;
  logic [FILL_W-1:0] fill_cur;
  logic [POS_W-1:0]  pos_cur;
  logic              full_cur;
  logic [HASH_W-1:0] word_in;
  logic [HASH_W-1:0] word_out;
  logic [HASH_W-1:0] word_out_rot;
  logic              accept;

  assign in_ready = !cand_valid || cand_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A stream start clears the state before the byte is taken in.
    hash_cur = stream_start ? '0 : hash;
    fill_cur = stream_start ? '0 : fill;
    pos_cur  = stream_start ? '0 : pos;
    full_cur = (fill_cur == FILL_FULL);

    word_in      = BYTE_TABLE[byte_value];
    word_out     = BYTE_TABLE[window[0]];
    word_out_rot = (word_out << ROT_OUT) | (word_out >> ROT_BACK);

    hash_next = {hash_cur[HASH_W-2:0], hash_cur[HASH_W-1]} ^ word_in;
    fill_next = fill_cur + FILL_W'(1);
    pos_next  = pos_cur;
    if (full_cur) begin
      hash_next = hash_next ^ word_out_rot;
      fill_next = fill_cur;
      if (pos_cur != POS_MAX) begin
        pos_next = pos_cur + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash       <= '0;
      fill       <= '0;
      pos        <= '0;
      cand_valid <= 1'b0;
    end else begin
      if (accept) begin
        hash       <= hash_next;
        fill       <= fill_next;
        pos        <= pos_next;
        cand_valid <= 1'b1;
      end else if (cand_take) begin
        cand_valid <= 1'b0;
      end
    end
  end

  // Shift line: oldest byte at entry 0 once the window is full.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[WINDOW-1] <= byte_value;
      cand.hash <= hash_next;
      cand.pos  <= pos_next;
      cand.full <= (fill_next == FILL_FULL);
    end
  end

endmodule

// File: sv/caf_anchor_stage.sv
// Mask register, anchor test and output register of the anchor finder.
// Depends on caf_pkg.
module caf_anchor_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  logic               cand_valid,
  input  caf_pkg::cand_t     cand,
  output logic               cand_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        anchor_position
);
  import caf_pkg::*;

  logic [HASH_W-1:0] mask;
  logic              is_anchor;
  logic              out_free;

  assign is_anchor = cand.full && ((cand.hash & mask) == '0);
  assign out_free  = !out_valid || out_ready;
  // Drop a non-anchor candidate at once; hold an anchor until the output frees.
  assign cand_take = cand_valid && (!is_anchor || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= MASK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask <= cfg_wr_data;
      end
      if (cand_valid && is_anchor && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_valid && is_anchor && out_free) begin
      anchor_position <= cand.pos;
    end
  end

endmodule

// File: sv/content_defined_anchor_finder_top.sv
// Content-defined anchor finder: takes one byte per beat and keeps a 64-bit
// buzhash over the last 32 bytes; when the window is full and the hash ANDed
// with anchor_mask is zero it emits the offset of the window's first byte.
// Throughput is one byte per clock unless the anchor output stalls; the hash
// update loop is two table lookups, a rotate and XORs. Anchors pass the candidate
// register, then the output register. stream_start on a beat restarts the hash,
// fill count and offset before that byte is taken in. Offsets saturate at
// 0xFFFFFFFF. anchor_mask (reset 63) may be written only while the block is idle.
// Depends on caf_pkg, caf_in_if, caf_out_if, caf_hash_stage, caf_anchor_stage.
module content_defined_anchor_finder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  caf_in_if.sink      byte_stream,
  caf_out_if.source   anchor_stream
);
  import caf_pkg::*;

  logic  cand_valid;
  logic  cand_take;
  cand_t cand;

  caf_hash_stage u_hash (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (byte_stream.valid),
    .in_ready     (byte_stream.ready),
    .byte_value   (byte_stream.byte_value),
    .stream_start (byte_stream.stream_start),
    .cand_valid   (cand_valid),
    .cand         (cand),
    .cand_take    (cand_take)
  );

  caf_anchor_stage u_anchor (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cand_valid      (cand_valid),
    .cand            (cand),
    .cand_take       (cand_take),
    .out_valid       (anchor_stream.valid),
    .out_ready       (anchor_stream.ready),
    .anchor_position (anchor_stream.anchor_position)
  );

endmodule
